FILE: hw/rtl/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// Types, widths and constants shared by the planar odometry integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package poi_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 16;

   // CORDIC datapath: Q2.30 with headroom for gain growth and negation
   localparam int unsigned CORDIC_W = 34;
   localparam int unsigned IDX_W    = 5;
   // multiplier: CORDIC-width operand by a sign-extended 32-bit or zero-extended 16-bit operand
   localparam int unsigned MUL_B_W  = 33;
   localparam int unsigned PROD_W   = CORDIC_W + MUL_B_W;

   localparam logic signed [CORDIC_W-1:0] GAIN_Q30     = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 34'sd2147483648;
   localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;

   // arctan(2^-i) in binary-angle units
   localparam logic [29:0] ATAN_TAB [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81,
      30'd41,        30'd20,        30'd10,        30'd5,
      30'd3,         30'd1,         30'd1,         30'd0
   };

   typedef struct packed {
      logic                func;
      logic signed [31:0]  vel_forward;
      logic signed [31:0]  vel_side;
      logic signed [31:0]  turn_rate;
      logic        [15:0]  time_step;
      logic signed [31:0]  new_x;
      logic signed [31:0]  new_y;
      logic        [31:0]  new_heading;
   } poi_req_payload_type;

   typedef struct packed {
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic        [31:0]  heading;
      logic signed [15:0]  quat_z;
      logic signed [15:0]  quat_w;
   } poi_rsp_payload_type;

   typedef struct packed {
      logic         start;
      logic [31:0]  angle;
   } poi_trig_cmd_type;

   typedef struct packed {
      logic                        busy;
      logic signed [CORDIC_W-1:0]  cos_val;
      logic signed [CORDIC_W-1:0]  sin_val;
   } poi_trig_type;

endpackage

`default_nettype wire

FILE: hw/rtl/poi_if.sv
// ----------------------------------------------------------------------------
// poi_if
// Valid/ready channels for the odometry request and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface poi_req_if import poi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   poi_req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface poi_rsp_if import poi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   poi_rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/poi_cordic.sv
// ----------------------------------------------------------------------------
// poi_cordic
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle, Q2.30,
// one micro-rotation per cycle, then a final sign fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module poi_cordic import poi_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire poi_trig_cmd_type  cmd,
   output poi_trig_type           trig
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORDIC_STEPS - 1);

   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic                       neg_ff, neg_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic                       run_ff, run_in;
   logic                       fin_ff, fin_in;

   logic signed [CORDIC_W-1:0] z_wide;
   logic signed [CORDIC_W-1:0] x_sh;
   logic signed [CORDIC_W-1:0] y_sh;
   logic signed [CORDIC_W-1:0] atan_val;

   assign z_wide   = {{(CORDIC_W-32){cmd.angle[31]}}, cmd.angle};
   assign x_sh     = x_ff >>> idx_ff;
   assign y_sh     = y_ff >>> idx_ff;
   assign atan_val = {{(CORDIC_W-30){1'b0}}, ATAN_TAB[idx_ff]};

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      neg_in = neg_ff;
      idx_in = idx_ff;
      run_in = run_ff;
      fin_in = 1'b0;
      if (cmd.start) begin
         // fold into the right half-plane; negate the results at the end
         x_in   = GAIN_Q30;
         y_in   = '0;
         idx_in = '0;
         run_in = 1'b1;
         if (z_wide > QUARTER_TURN) begin
            z_in   = z_wide - HALF_TURN;
            neg_in = 1'b1;
         end else if (z_wide < -QUARTER_TURN) begin
            z_in   = z_wide + HALF_TURN;
            neg_in = 1'b1;
         end else begin
            z_in   = z_wide;
            neg_in = 1'b0;
         end
      end else if (run_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_val;
         end
         if (idx_ff == LAST_IDX) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (fin_ff) begin
         if (neg_ff) begin
            x_in = -x_ff;
            y_in = -y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
      idx_ff <= idx_in;
   end

   assign trig.busy    = run_ff | fin_ff;
   assign trig.cos_val = x_ff;
   assign trig.sin_val = y_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/planar_odometry_integrator_unit.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit
// Dead-reckoning pose integrator for a holonomic base. An integrate beat
// advances the heading by turn_rate * time_step, rotates the body-frame
// displacement by the new heading and adds it to the saturating x/y position;
// a set beat loads the pose. Every beat returns one response with the pose and
// the yaw quaternion. The block takes one beat at a time: an integrate beat
// makes two passes through the single iterative CORDIC (each a start, the
// micro-rotations and a sign fix-up), one for the new heading and one for the
// half heading of the quaternion, and uses the shared 34x33 multiplier, which
// forms the three scalings and the four rotation products one per cycle;
// a set beat makes only the quaternion pass. The response sits in an output
// register, so a new request is taken while the previous response still
// waits; a beat that finishes while that register is still full holds until
// it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_odometry_integrator_unit import poi_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   poi_req_if.sink    req,
   poi_rsp_if.source  rsp
);

   typedef enum logic [14:0] {
      S_IDLE     = 15'h0001,
      S_DHEAD    = 15'h0002,
      S_DX       = 15'h0004,
      S_DY       = 15'h0008,
      S_ROT_GO   = 15'h0010,
      S_ROT_WAIT = 15'h0020,
      S_P0       = 15'h0040,
      S_P1       = 15'h0080,
      S_P2       = 15'h0100,
      S_P3       = 15'h0200,
      S_P4       = 15'h0400,
      S_P5       = 15'h0800,
      S_P6       = 15'h1000,
      S_Q_GO     = 15'h2000,
      S_Q_WAIT   = 15'h4000
   } state_type;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd536870912);

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -38'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W:0]    t;
      logic signed [CORDIC_W-15:0] q;
      logic signed [15:0]          r;
      t = {v[CORDIC_W-1], v} + (CORDIC_W+1)'(16384);
      q = t[CORDIC_W:15];
      if (q > (CORDIC_W-14)'(32767)) begin
         r = 16'h7FFF;
      end else if (q < -(CORDIC_W-14)'(32768)) begin
         r = 16'h8000;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

   state_type                state_ff, state_in;
   logic signed [31:0]       turn_ff, turn_in;
   logic signed [31:0]       vf_ff, vf_in;
   logic signed [31:0]       vs_ff, vs_in;
   logic [15:0]              dt_ff, dt_in;
   logic signed [31:0]       dx_ff, dx_in;
   logic signed [31:0]       dy_ff, dy_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [36:0]       tx_ff, tx_in;
   logic signed [31:0]       x_ff, x_in;
   logic signed [31:0]       y_ff, y_in;
   logic [31:0]              heading_ff, heading_in;
   poi_rsp_payload_type      rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [CORDIC_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   acc_rnd;
   logic signed [37:0]         x_sum;
   logic signed [37:0]         y_sum;
   logic                       req_beat;
   poi_trig_cmd_type           trig_cmd;
   poi_trig_type               trig;

   poi_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (trig_cmd),
      .trig  (trig)
   );

   assign req_beat  = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   assign trig_cmd.start = (state_ff == S_ROT_GO) || (state_ff == S_Q_GO);
   assign trig_cmd.angle = (state_ff == S_Q_GO) ? {1'b0, heading_ff[31:1]} : heading_ff;

   assign acc_rnd = acc_ff + ROUND_HALF;
   assign x_sum   = {{6{x_ff[31]}}, x_ff} + {tx_ff[36], tx_ff};
   assign y_sum   = {{6{y_ff[31]}}, y_ff} + {tx_ff[36], tx_ff};

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_DHEAD: begin
            mul_a = {{(CORDIC_W-32){turn_ff[31]}}, turn_ff};
            mul_b = {{(MUL_B_W-16){1'b0}}, dt_ff};
         end
         S_DX: begin
            mul_a = {{(CORDIC_W-32){vf_ff[31]}}, vf_ff};
            mul_b = {{(MUL_B_W-16){1'b0}}, dt_ff};
         end
         S_DY: begin
            mul_a = {{(CORDIC_W-32){vs_ff[31]}}, vs_ff};
            mul_b = {{(MUL_B_W-16){1'b0}}, dt_ff};
         end
         S_P0: begin
            mul_a = trig.cos_val;
            mul_b = {dx_ff[31], dx_ff};
         end
         S_P1: begin
            mul_a = trig.sin_val;
            mul_b = {dy_ff[31], dy_ff};
         end
         S_P2: begin
            mul_a = trig.sin_val;
            mul_b = {dx_ff[31], dx_ff};
         end
         S_P3: begin
            mul_a = trig.cos_val;
            mul_b = {dy_ff[31], dy_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      turn_in      = turn_ff;
      vf_in        = vf_ff;
      vs_in        = vs_ff;
      dt_in        = dt_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      tx_in        = tx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      heading_in   = heading_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (req.payload.func) begin
                  x_in       = req.payload.new_x;
                  y_in       = req.payload.new_y;
                  heading_in = req.payload.new_heading;
                  state_in   = S_Q_GO;
               end else begin
                  turn_in  = req.payload.turn_rate;
                  vf_in    = req.payload.vel_forward;
                  vs_in    = req.payload.vel_side;
                  dt_in    = req.payload.time_step;
                  state_in = S_DHEAD;
               end
            end
         end
         S_DHEAD: state_in = S_DX;
         S_DX: begin
            // floor(w * dt / 2^16), wrapped into the heading
            heading_in = heading_ff + prod_ff[47:16];
            state_in   = S_DY;
         end
         S_DY: begin
            dx_in    = prod_ff[47:16];
            state_in = S_ROT_GO;
         end
         S_ROT_GO: begin
            dy_in    = prod_ff[47:16];
            state_in = S_ROT_WAIT;
         end
         S_ROT_WAIT: begin
            if (!trig.busy) begin
               state_in = S_P0;
            end
         end
         S_P0: state_in = S_P1;
         S_P1: begin
            acc_in   = prod_ff;
            state_in = S_P2;
         end
         S_P2: begin
            acc_in   = acc_ff - prod_ff;
            state_in = S_P3;
         end
         S_P3: begin
            tx_in    = acc_rnd[PROD_W-1:30];
            acc_in   = prod_ff;
            state_in = S_P4;
         end
         S_P4: begin
            x_in     = sat32(x_sum);
            acc_in   = acc_ff + prod_ff;
            state_in = S_P5;
         end
         S_P5: begin
            tx_in    = acc_rnd[PROD_W-1:30];
            state_in = S_P6;
         end
         S_P6: begin
            y_in     = sat32(y_sum);
            state_in = S_Q_GO;
         end
         S_Q_GO: state_in = S_Q_WAIT;
         S_Q_WAIT: begin
            // hold until the CORDIC is done and the output register is free
            if (!trig.busy && (!rsp_valid_ff || rsp.ready)) begin
               rsp_in.pos_x   = x_ff;
               rsp_in.pos_y   = y_ff;
               rsp_in.heading = heading_ff;
               rsp_in.quat_z  = to_q15(trig.sin_val);
               rsp_in.quat_w  = to_q15(trig.cos_val);
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         heading_ff   <= heading_in;
      end
      turn_ff <= turn_in;
      vf_ff   <= vf_in;
      vs_ff   <= vs_in;
      dt_ff   <= dt_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      tx_ff   <= tx_in;
      rsp_ff  <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_idle_trig_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !trig.busy)
      else $error("CORDIC busy while the sequencer is idle");

   a_trig_started: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT_GO || state_ff == S_Q_GO) |=> trig.busy)
      else $error("CORDIC did not start");

   a_set_pose: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req.payload.func) |=>
         (heading_ff == $past(req.payload.new_heading) && x_ff == $past(req.payload.new_x)
          && state_ff == S_Q_GO))
      else $error("set-pose beat not loaded");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/planar_odometry_integrator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit_tb
// Self-checking bench for the odometry integrator. A short table of directed
// beats covers zero steps, field extremes, heading wrap, the quadrant folds
// and pose loads. About two thousand random beats follow. Every response is
// checked field by field against a bit-exact fixed-point predictor. Request
// bursts, receiver stalls and long response hold-offs vary the timing.
// ----------------------------------------------------------------------------

module planar_odometry_integrator_unit_tb;
   import poi_pkg::*;

   localparam int unsigned ROT_STEPS    = CORDIC_STEPS_DEF;
   localparam int          RANDOM_BEATS = 2000;
   localparam int          LONG_HOLD    = 400;
   localparam int          DRAIN_CYCLES = 80;
   localparam int          LIMIT_CYCLES = 1500000;

   localparam logic OP_INTEGRATE = 1'b0;
   localparam logic OP_SET_POSE  = 1'b1;

   localparam longint ROT_GAIN     = 64'sd652032874;
   localparam longint TURN_HALF    = 64'sd2147483648;
   localparam longint TURN_QUARTER = 64'sd1073741824;
   localparam longint ROUND_Q30    = 64'sd536870912;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   // one directed beat; the pose fields hold a typed-in answer where known
   typedef struct packed {
      poi_req_payload_type  beat;
      logic                 pose_known;
      logic signed [31:0]   x;
      logic signed [31:0]   y;
      logic        [31:0]   h;
   } plan_row_type;

   logic clock;
   logic reset;

   poi_req_if req_bus ();
   poi_rsp_if rsp_bus ();

   planar_odometry_integrator_unit #(
      .CORDIC_STEPS (ROT_STEPS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // predictor state
   logic signed [31:0]  pose_x;
   logic signed [31:0]  pose_y;
   logic        [31:0]  pose_heading;

   poi_rsp_payload_type pose_expect_q [$];
   poi_rsp_payload_type want_rsp;

   int fault_count;
   int rsp_seen;
   int n_integrate;
   int n_set;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint arc_step(input int i);
      case (i)
         0: return 536870912;   1: return 316933406;   2: return 167458907;
         3: return 85004756;    4: return 42667331;    5: return 21354465;
         6: return 10679838;    7: return 5340245;     8: return 2670163;
         9: return 1335087;    10: return 667544;     11: return 333772;
        12: return 166886;     13: return 83443;      14: return 41722;
        15: return 20861;      16: return 10430;      17: return 5215;
        18: return 2608;       19: return 1304;       20: return 652;
        21: return 326;        22: return 163;        23: return 81;
        24: return 41;         25: return 20;         26: return 10;
        27: return 5;          28: return 3;          29: return 1;
        30: return 1;          default: return 0;
      endcase
   endfunction

   // cosine and sine of a binary angle, Q2.30
   task automatic rotate_binary_angle(input logic [31:0] ang, output longint c,
                                      output longint s);
      longint z, x, y, t;
      bit     flip;
      int     i;
      z = {32'd0, ang};
      x = ROT_GAIN;
      y = 0;
      flip = 1'b0;
      if (z >= TURN_HALF) z = z - 2 * TURN_HALF;
      // fold into the right half plane, negate on the way out
      if (z > TURN_QUARTER) begin
         z = z - TURN_HALF;
         flip = 1'b1;
      end else if (z < -TURN_QUARTER) begin
         z = z + TURN_HALF;
         flip = 1'b1;
      end
      for (i = 0; i < ROT_STEPS && i < 32; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arc_step(i);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arc_step(i);
         end
         x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [15:0] q15_round(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   task automatic odom_predict(input poi_req_payload_type p,
                               output poi_rsp_payload_type r);
      longint vf, vs, w, dt, delta, dx, dy, c, s, tx, ty, acc;
      if (p.func == OP_SET_POSE) begin
         pose_x       = p.new_x;
         pose_y       = p.new_y;
         pose_heading = p.new_heading;
      end else begin
         vf = $signed(p.vel_forward);
         vs = $signed(p.vel_side);
         w  = $signed(p.turn_rate);
         dt = {48'd0, p.time_step};
         delta = (w * dt) >>> 16;
         dx    = (vf * dt) >>> 16;
         dy    = (vs * dt) >>> 16;
         // heading first, then rotate by the new heading
         pose_heading = pose_heading + delta[31:0];
         rotate_binary_angle(pose_heading, c, s);
         tx = (c * dx - s * dy + ROUND_Q30) >>> 30;
         ty = (s * dx + c * dy + ROUND_Q30) >>> 30;
         acc = pose_x;
         pose_x = sat32(acc + tx);
         acc = pose_y;
         pose_y = sat32(acc + ty);
      end
      rotate_binary_angle(pose_heading >> 1, c, s);
      r.pos_x   = pose_x;
      r.pos_y   = pose_y;
      r.heading = pose_heading;
      r.quat_z  = q15_round(s);
      r.quat_w  = q15_round(c);
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic plan_row_type mk_row(input logic f, input logic [31:0] vf,
                                           input logic [31:0] vs, input logic [31:0] w,
                                           input logic [15:0] dt, input logic [31:0] nx,
                                           input logic [31:0] ny, input logic [31:0] nh,
                                           input logic known, input logic [31:0] ex,
                                           input logic [31:0] ey, input logic [31:0] eh);
      plan_row_type row;
      row.beat.func        = f;
      row.beat.vel_forward = vf;
      row.beat.vel_side    = vs;
      row.beat.turn_rate   = w;
      row.beat.time_step   = dt;
      row.beat.new_x       = nx;
      row.beat.new_y       = ny;
      row.beat.new_heading = nh;
      row.pose_known       = known;
      row.x                = ex;
      row.y                = ey;
      row.h                = eh;
      return row;
   endfunction

   function automatic logic [31:0] rand_small(input int bits);
      logic [31:0] v;
      v = $urandom & ((32'd1 << (bits + 1)) - 1);
      return v - (32'd1 << bits);
   endfunction

   function automatic logic [31:0] rand_velocity();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return rand_small(20);
      endcase
   endfunction

   function automatic poi_req_payload_type rand_beat();
      poi_req_payload_type b;
      b.func        = ($urandom_range(0, 99) < 8) ? OP_SET_POSE : OP_INTEGRATE;
      b.vel_forward = rand_velocity();
      b.vel_side    = rand_velocity();
      b.turn_rate   = ($urandom_range(0, 3) == 0) ? $urandom : rand_small(28);
      case ($urandom_range(0, 19))
         0, 1:    b.time_step = 16'($urandom);
         2:       b.time_step = 16'h0000;
         3:       b.time_step = 16'hFFFF;
         default: b.time_step = 16'($urandom_range(0, 6554));
      endcase
      b.new_x       = ($urandom_range(0, 3) == 0) ? $urandom : rand_small(22);
      b.new_y       = ($urandom_range(0, 3) == 0) ? $urandom : rand_small(22);
      b.new_heading = $urandom;
      return b;
   endfunction

   // hold valid until the beat is taken
   task automatic offer_beat(input poi_req_payload_type p);
      req_bus.valid   <= 1'b1;
      req_bus.payload <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (p.func == OP_SET_POSE) n_set++;
      else n_integrate++;
   endtask

   task automatic idle_gap(input int n);
      if (n != 0) begin
         req_bus.valid   <= 1'b0;
         req_bus.payload <= rand_beat();
         repeat (n) @(posedge clock);
      end
   endtask

   // drop valid and wait for every outstanding response
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pose_expect_q.size() != 0);
   endtask

   initial begin : req_side
      plan_row_type        plan [$];
      plan_row_type        row;
      poi_rsp_payload_type guess;
      int                  sent;
      int                  burst;
      bit                  paused;

      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      pose_x          = '0;
      pose_y          = '0;
      pose_heading    = '0;

      plan.push_back(mk_row(OP_INTEGRATE, 0, 0, 0, 16'h0000, 0, 0, 0,
                            1'b1, 0, 0, 0));
      // zero time step with extreme rates and junk pose fields
      plan.push_back(mk_row(OP_INTEGRATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            16'h0000, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF,
                            1'b1, 0, 0, 0));
      plan.push_back(mk_row(OP_SET_POSE, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                            16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                            1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 0));
      plan.push_back(mk_row(OP_INTEGRATE, 32'h7FFF_FFFF, 0, 0, 16'hFFFF, 0, 0, 0,
                            1'b0, 0, 0, 0));
      plan.push_back(mk_row(OP_INTEGRATE, 0, 32'h8000_0000, 0, 16'hFFFF, 0, 0, 0,
                            1'b0, 0, 0, 0));
      plan.push_back(mk_row(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
                            1'b1, 0, 0, 32'hFFFF_FFFF));
      // heading wraps through zero, quaternion flips sign
      plan.push_back(mk_row(OP_INTEGRATE, 0, 0, 32'h0001_0000, 16'h0001, 0, 0, 0,
                            1'b1, 0, 0, 0));
      // smallest negative step floors to minus one
      plan.push_back(mk_row(OP_INTEGRATE, 0, 0, 32'hFFFF_FFFF, 16'h0001, 0, 0, 0,
                            1'b1, 0, 0, 32'hFFFF_FFFF));
      plan.push_back(mk_row(OP_INTEGRATE, 0, 0, 32'hFFFF_0000, 16'h0001, 0, 0, 0,
                            1'b1, 0, 0, 32'hFFFF_FFFE));
      plan.push_back(mk_row(OP_SET_POSE, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h4000_0000, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h4000_0000));
      plan.push_back(mk_row(OP_INTEGRATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            16'hFFFF, 0, 0, 0, 1'b0, 0, 0, 0));
      plan.push_back(mk_row(OP_INTEGRATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            16'hFFFF, 0, 0, 0, 1'b0, 0, 0, 0));
      plan.push_back(mk_row(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 32'h8000_0000,
                            1'b1, 0, 0, 32'h8000_0000));
      plan.push_back(mk_row(OP_INTEGRATE, 32'h0001_0000, 0, 0, 16'h8000, 0, 0, 0,
                            1'b0, 0, 0, 0));
      plan.push_back(mk_row(OP_INTEGRATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'hFFFF,
                            0, 0, 0, 1'b0, 0, 0, 0));
      // half heading right at and just past the quarter turn
      plan.push_back(mk_row(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 32'h8000_0001,
                            1'b1, 0, 0, 32'h8000_0001));
      plan.push_back(mk_row(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 32'h8000_0002,
                            1'b1, 0, 0, 32'h8000_0002));
      plan.push_back(mk_row(OP_SET_POSE, 0, 0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF,
                            32'hC000_0000, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF,
                            32'hC000_0000));
      plan.push_back(mk_row(OP_INTEGRATE, 0, 32'h0001_0000, 32'h0100_0000, 16'h1000,
                            0, 0, 0, 1'b0, 0, 0, 0));
      plan.push_back(mk_row(OP_SET_POSE, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h2000_0000, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h2000_0000));
      plan.push_back(mk_row(OP_INTEGRATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'hFFFF,
                            0, 0, 0, 1'b0, 0, 0, 0));
      plan.push_back(mk_row(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0));
      plan.push_back(mk_row(OP_INTEGRATE, 32'h0028_0000, 32'hFFE0_0000, 32'h1000_0000,
                            16'h199A, 0, 0, 0, 1'b0, 0, 0, 0));

      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         offer_beat(row.beat);
         odom_predict(row.beat, guess);
         if (row.pose_known) begin
            guess.pos_x   = row.x;
            guess.pos_y   = row.y;
            guess.heading = row.h;
         end
         pose_expect_q.push_back(guess);
         idle_gap($urandom_range(0, 3));
      end
      settle();

      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            if (sent < RANDOM_BEATS) begin
               row.beat = rand_beat();
               offer_beat(row.beat);
               odom_predict(row.beat, guess);
               pose_expect_q.push_back(guess);
               sent++;
            end
         end
         if (!paused && sent >= RANDOM_BEATS / 2) begin
            settle();
            paused = 1'b1;
         end else if ($urandom_range(0, 3) != 0) begin
            idle_gap($urandom_range(1, 30));
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Accepted %0d integrate and %0d set-pose beats; checked %0d responses.",
               n_integrate, n_set, rsp_seen);
      $display("Stimulus spanned zero steps, heading wrap, quadrant folds, saturation",
               " and two long response hold-offs.");
      if (fault_count == 0 && pose_expect_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   initial begin : rsp_side
      stall_mode_type mode;
      int             span;
      bit             held_early;
      bit             held_late;

      rsp_bus.ready = 1'b0;
      held_early    = 1'b0;
      held_late     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // long hold-off lets the block fill and back-pressure the request side
         if ((!held_early && rsp_seen >= 300) || (!held_late && rsp_seen >= 1300)) begin
            if (!held_early) held_early = 1'b1;
            else held_late = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(1, 80);
         repeat (span) begin
            case (mode)
               STALL_NONE:  rsp_bus.ready <= 1'b1;
               STALL_COIN:  rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               STALL_LIGHT: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               default:     rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
         fault_count++;
      end
   endtask

   initial begin
      fault_count = 0;
      rsp_seen    = 0;
      n_integrate = 0;
      n_set       = 0;
      cycle_count = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen++;
         if (pose_expect_q.size() == 0) begin
            $error("response beat with no pending prediction: x 0x%08h y 0x%08h",
                   rsp_bus.payload.pos_x, rsp_bus.payload.pos_y);
            fault_count++;
         end else begin
            want_rsp = pose_expect_q.pop_front();
            check_field("pos_x", want_rsp.pos_x, rsp_bus.payload.pos_x);
            check_field("pos_y", want_rsp.pos_y, rsp_bus.payload.pos_y);
            check_field("heading", want_rsp.heading, rsp_bus.payload.heading);
            check_field("quat_z", {16'd0, want_rsp.quat_z}, {16'd0, rsp_bus.payload.quat_z});
            check_field("quat_w", {16'd0, want_rsp.quat_w}, {16'd0, rsp_bus.payload.quat_w});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $error("timeout after %0d cycles, %0d responses pending",
                cycle_count, pose_expect_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

FILE: planar_odometry_integrator_unit.f
hw/rtl/poi_pkg.sv
hw/rtl/poi_if.sv
hw/rtl/poi_cordic.sv
hw/rtl/planar_odometry_integrator_unit.sv
tb/sv/planar_odometry_integrator_unit_tb.sv
